// File: rtl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int KEY_W = 16;
  localparam int TAG_W = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } spq_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } spq_cmd_t;

endpackage

// File: rtl/spq_ctrl.sv
// Controller: sequences request capture, execution and result handoff.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  spq_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The queue update waits until the result register is free.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/spq_datapath.sv
// Datapath: sorted entry row with parallel compare-and-shift, and result register.
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spq_pkg::spq_cmd_t              cmd,
  input  logic                           req_type,
  input  logic [spq_pkg::KEY_W-1:0]      job_key,
  input  logic [spq_pkg::TAG_W-1:0]      job_tag,
  output logic [spq_pkg::STATUS_W-1:0]   status,
  output logic [spq_pkg::KEY_W-1:0]      popped_key,
  output logic [spq_pkg::TAG_W-1:0]      popped_tag,
  output logic [spq_pkg::OCC_W-1:0]      occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic             req_r;
  logic [KEY_W-1:0] key_r;
  logic [TAG_W-1:0] tag_r;

  logic [KEY_W-1:0] keys [QUEUE_DEPTH];
  logic [TAG_W-1:0] tags [QUEUE_DEPTH];
  logic [KEY_W-1:0] keys_next [QUEUE_DEPTH];
  logic [TAG_W-1:0] tags_next [QUEUE_DEPTH];
  logic [CW-1:0]    count, count_next;
  logic [QUEUE_DEPTH-1:0] at_or_after;
  logic             is_full, is_empty;
  logic [STATUS_W-1:0] status_next;
  logic [KEY_W-1:0] pkey_next;
  logic [TAG_W-1:0] ptag_next;
  logic [CW+OCC_W-1:0] occ_ext;

  assign is_full = (count == CW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  // A cell is at or after the insert point when it is unused or holds a key
  // not smaller than the new key; the row is sorted, so this is monotonic.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      at_or_after[i] = (CW'(i) >= count) || (key_r <= keys[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keys_next[i] = keys[i];
      tags_next[i] = tags[i];
    end
    count_next = count;
    status_next = STATUS_OK;
    pkey_next = '0;
    ptag_next = '0;
    if (req_r == REQ_INSERT) begin
      if (is_full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + 1'b1;
        if (at_or_after[0]) begin
          keys_next[0] = key_r;
          tags_next[0] = tag_r;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (at_or_after[i]) begin
            if (!at_or_after[i-1]) begin
              keys_next[i] = key_r;
              tags_next[i] = tag_r;
            end else begin
              keys_next[i] = keys[i-1];
              tags_next[i] = tags[i-1];
            end
          end
        end
      end
    end else begin
      if (is_empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        count_next = count - 1'b1;
        pkey_next = keys[0];
        ptag_next = tags[0];
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          keys_next[i] = keys[i+1];
          tags_next[i] = tags[i+1];
        end
      end
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req_type;
      key_r <= job_key;
      tag_r <= job_tag;
    end
    if (cmd.commit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        keys[i] <= keys_next[i];
        tags[i] <= tags_next[i];
      end
      status <= status_next;
      popped_key <= pkey_next;
      popped_tag <= ptag_next;
      occupancy <= occ_ext[OCC_W-1:0];
    end
  end

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// A request is captured into the request registers, and its result is registered when
// the queue update commits. The controller captures a request and then applies the
// compare-and-shift pass over the sorted entry row; a pending result stalls only that
// update, and no new request is taken until the update has committed.
// A new request may be taken while the previous result still waits at the output.
// Reset empties the queue and clears the handshake; stored entries are not cleared.
// Occupancy reports the entry count modulo 32.
module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [spq_pkg::KEY_W-1:0]    job_key,
  input  logic [spq_pkg::TAG_W-1:0]    job_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spq_pkg::STATUS_W-1:0] status,
  output logic [spq_pkg::KEY_W-1:0]    popped_key,
  output logic [spq_pkg::TAG_W-1:0]    popped_tag,
  output logic [spq_pkg::OCC_W-1:0]    occupancy
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .job_key    (job_key),
    .job_tag    (job_tag),
    .status     (status),
    .popped_key (popped_key),
    .popped_tag (popped_tag),
    .occupancy  (occupancy)
  );

endmodule
